// ===== src/sss_pkg.sv =====
package sss_pkg;

   localparam int SAMPLE_W            = 16;
   localparam int SQUARE_W            = 2 * SAMPLE_W - 1;
   localparam int DEFAULT_MAX_SAMPLES = 1024;
   localparam int MEAN_W              = 24;
   localparam int DEV_W               = 24;
   localparam int COUNT_OUT_W         = 11;
   localparam int MEAN_FRAC           = 8;
   localparam int VAR_FRAC            = 2 * MEAN_FRAC;
   // The scaled variance never exceeds 2^46, so a 48-bit radicand is enough.
   localparam int ROOT_IN_W           = 48;
   localparam int QUEUE_DEPTH         = 2;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] sample;
      logic                       last_sample;
   } req_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] max_value;
      logic signed [SAMPLE_W-1:0] min_value;
      logic signed [MEAN_W-1:0]   mean_q8;
      logic [DEV_W-1:0]           std_dev_q8;
      logic [COUNT_OUT_W-1:0]     sample_count;
      logic                       overflowed;
   } rsp_type;

endpackage

// ===== src/sss_front.sv =====
module sss_front import sss_pkg::*; #(
   parameter int MAX_SAMPLES = DEFAULT_MAX_SAMPLES,
   parameter int DEPTH       = QUEUE_DEPTH,
   localparam int CW  = $clog2(MAX_SAMPLES + 1),
   localparam int SW  = SAMPLE_W + CW,
   localparam int QW  = 2 * SAMPLE_W - 2 + CW,
   localparam int QCW = $clog2(DEPTH + 1)
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  req_type                    req_data,
   output logic                       busy,
   input  logic [QCW-1:0]             queue_level,
   output logic                       snap_push,
   output logic [CW-1:0]              snap_count,
   output logic signed [SW-1:0]       snap_sum,
   output logic [QW-1:0]              snap_sumsq,
   output logic signed [SAMPLE_W-1:0] snap_min,
   output logic signed [SAMPLE_W-1:0] snap_max,
   output logic                       snap_ovf
);

   logic                       accept;
   logic signed [2*SAMPLE_W-1:0] sample_ext;
   logic signed [2*SAMPLE_W-1:0] square_full;
   logic [QCW:0]               reserved;

   logic                       s1_valid_ff, s1_valid_in;
   logic                       s1_last_ff;
   logic signed [SAMPLE_W-1:0] s1_sample_ff;
   logic [SQUARE_W-1:0]        s1_square_ff;

   logic [CW-1:0]              acc_count_ff, acc_count_in;
   logic signed [SW-1:0]       acc_sum_ff, acc_sum_in;
   logic [QW-1:0]              acc_sumsq_ff, acc_sumsq_in;
   logic signed [SAMPLE_W-1:0] acc_min_ff, acc_min_in;
   logic signed [SAMPLE_W-1:0] acc_max_ff, acc_max_in;
   logic                       acc_ovf_ff, acc_ovf_in;

   logic                       room;
   logic [CW-1:0]              next_count;
   logic signed [SW-1:0]       next_sum;
   logic [QW-1:0]              next_sumsq;
   logic signed [SAMPLE_W-1:0] next_min;
   logic signed [SAMPLE_W-1:0] next_max;
   logic                       next_ovf;

   // A last sample in the capture stage has already claimed a queue slot.
   assign reserved    = {1'b0, queue_level} + (QCW+1)'(s1_valid_ff && s1_last_ff);
   assign busy        = reserved >= (QCW+1)'(DEPTH);
   assign accept      = start && !busy;
   assign s1_valid_in = accept;
   assign sample_ext  = (2*SAMPLE_W)'(req_data.sample);
   assign square_full = sample_ext * sample_ext;

   always_comb begin
      room       = acc_count_ff < CW'(MAX_SAMPLES);
      next_count = acc_count_ff;
      next_sum   = acc_sum_ff;
      next_sumsq = acc_sumsq_ff;
      next_min   = acc_min_ff;
      next_max   = acc_max_ff;
      next_ovf   = acc_ovf_ff;
      if (s1_valid_ff) begin
         if (room) begin
            next_count = acc_count_ff + 1'b1;
            next_sum   = acc_sum_ff + SW'(s1_sample_ff);
            next_sumsq = acc_sumsq_ff + QW'(s1_square_ff);
            if (acc_count_ff == '0) begin
               next_min = s1_sample_ff;
               next_max = s1_sample_ff;
            end else begin
               if (s1_sample_ff < acc_min_ff) begin
                  next_min = s1_sample_ff;
               end
               if (s1_sample_ff > acc_max_ff) begin
                  next_max = s1_sample_ff;
               end
            end
         end else begin
            next_ovf = 1'b1;
         end
      end

      snap_push  = s1_valid_ff && s1_last_ff;
      snap_count = next_count;
      snap_sum   = next_sum;
      snap_sumsq = next_sumsq;
      snap_min   = next_min;
      snap_max   = next_max;
      snap_ovf   = next_ovf;

      if (snap_push) begin
         acc_count_in = '0;
         acc_sum_in   = '0;
         acc_sumsq_in = '0;
         acc_min_in   = '0;
         acc_max_in   = '0;
         acc_ovf_in   = 1'b0;
      end else begin
         acc_count_in = next_count;
         acc_sum_in   = next_sum;
         acc_sumsq_in = next_sumsq;
         acc_min_in   = next_min;
         acc_max_in   = next_max;
         acc_ovf_in   = next_ovf;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         acc_count_ff <= '0;
         acc_sum_ff   <= '0;
         acc_sumsq_ff <= '0;
         acc_min_ff   <= '0;
         acc_max_ff   <= '0;
         acc_ovf_ff   <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         acc_count_ff <= acc_count_in;
         acc_sum_ff   <= acc_sum_in;
         acc_sumsq_ff <= acc_sumsq_in;
         acc_min_ff   <= acc_min_in;
         acc_max_ff   <= acc_max_in;
         acc_ovf_ff   <= acc_ovf_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_last_ff   <= req_data.last_sample;
         s1_sample_ff <= req_data.sample;
         s1_square_ff <= square_full[SQUARE_W-1:0];
      end
   end

endmodule

// ===== src/sss_queue.sv =====
module sss_queue import sss_pkg::*; #(
   parameter int WIDTH = 1,
   parameter int DEPTH = QUEUE_DEPTH,
   localparam int PTR_W = $clog2(DEPTH),
   localparam int QCW   = $clog2(DEPTH + 1)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   input  logic             pop,
   output logic             out_valid,
   output logic [WIDTH-1:0] out_data,
   output logic [QCW-1:0]   level
);

   logic [WIDTH-1:0] entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCW-1:0]   count_ff, count_in;
   logic             do_pop;

   assign out_valid = count_ff != '0;
   assign out_data  = entry_ff[rd_ptr_ff];
   assign level     = count_ff;
   assign do_pop    = pop && out_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== src/sss_back.sv =====
module sss_back import sss_pkg::*; #(
   parameter int MAX_SAMPLES = DEFAULT_MAX_SAMPLES,
   localparam int CW = $clog2(MAX_SAMPLES + 1),
   localparam int SW = SAMPLE_W + CW,
   localparam int QW = 2 * SAMPLE_W - 2 + CW
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       snap_valid,
   input  logic [CW-1:0]              snap_count,
   input  logic signed [SW-1:0]       snap_sum,
   input  logic [QW-1:0]              snap_sumsq,
   input  logic signed [SAMPLE_W-1:0] snap_min,
   input  logic signed [SAMPLE_W-1:0] snap_max,
   input  logic                       snap_ovf,
   output logic                       snap_pop,
   output logic                       rsp_valid,
   output rsp_type                    rsp_data
);

   localparam int AW     = SW - 1;
   localparam int PW     = CW + QW;
   localparam int NW     = 2 * CW;
   localparam int DVW    = PW + VAR_FRAC;
   localparam int STEP_W = $clog2(DVW);
   localparam int ROOT_W = ROOT_IN_W / 2;
   localparam int RRW    = ROOT_W + 2;

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_MUL  = 5'b00010,
      ST_DIFF = 5'b00100,
      ST_DIV  = 5'b01000,
      ST_ROOT = 5'b10000
   } state_type;

   // One more state would be needed for the result, so it is folded into the
   // root loop's exit: the output register loads as the last root step ends.
   state_type state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;

   logic [CW-1:0]              count_ff, count_in;
   logic                       sum_neg_ff, sum_neg_in;
   logic [AW-1:0]              abs_sum_ff, abs_sum_in;
   logic signed [SAMPLE_W-1:0] min_ff, min_in;
   logic signed [SAMPLE_W-1:0] max_ff, max_in;
   logic                       ovf_ff, ovf_in;

   logic [CW-1:0] mplier_n_ff, mplier_n_in;
   logic [PW-1:0] mcand_sq_ff, mcand_sq_in;
   logic [NW-1:0] mcand_n_ff, mcand_n_in;
   logic [PW-1:0] prod_nq_ff, prod_nq_in;
   logic [NW-1:0] prod_nn_ff, prod_nn_in;
   logic [AW-1:0] mplier_s_ff, mplier_s_in;
   logic [PW-1:0] mcand_s_ff, mcand_s_in;
   logic [PW-1:0] prod_ss_ff, prod_ss_in;

   logic [DVW-1:0] dq_ff, dq_in;
   logic [NW-1:0]  drem_ff, drem_in;
   logic [DVW-1:0] mq_ff, mq_in;
   logic [CW-1:0]  mrem_ff, mrem_in;

   logic [ROOT_IN_W-1:0] rad_ff, rad_in;
   logic [RRW-1:0]       rrem_ff, rrem_in;
   logic [ROOT_W-1:0]    root_ff, root_in;

   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff, rsp_data_in;

   logic [AW-1:0]     abs_snap;
   logic [PW-1:0]     diff;
   logic [NW:0]       d_trial;
   logic [CW:0]       m_trial;
   logic [DVW-1:0]    dq_next;
   logic [RRW-1:0]    r_shift;
   logic [RRW-1:0]    r_trial;
   logic [ROOT_W-1:0] root_next;
   logic [MEAN_W-1:0] mean_q;
   logic [MEAN_W-1:0] mean_abs;
   logic [MEAN_W-1:0] mean_val;

   assign snap_pop  = (state_ff == ST_IDLE) && snap_valid;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      count_in     = count_ff;
      sum_neg_in   = sum_neg_ff;
      abs_sum_in   = abs_sum_ff;
      min_in       = min_ff;
      max_in       = max_ff;
      ovf_in       = ovf_ff;
      mplier_n_in  = mplier_n_ff;
      mcand_sq_in  = mcand_sq_ff;
      mcand_n_in   = mcand_n_ff;
      prod_nq_in   = prod_nq_ff;
      prod_nn_in   = prod_nn_ff;
      mplier_s_in  = mplier_s_ff;
      mcand_s_in   = mcand_s_ff;
      prod_ss_in   = prod_ss_ff;
      dq_in        = dq_ff;
      drem_in      = drem_ff;
      mq_in        = mq_ff;
      mrem_in      = mrem_ff;
      rad_in       = rad_ff;
      rrem_in      = rrem_ff;
      root_in      = root_ff;
      rsp_valid_in = 1'b0;
      rsp_data_in  = rsp_data_ff;

      abs_snap = AW'(snap_sum[SW-1] ? -snap_sum : snap_sum);
      diff     = (prod_nq_ff >= prod_ss_ff) ? prod_nq_ff - prod_ss_ff : '0;

      // Restoring division, one quotient bit per cycle for both dividers.
      d_trial = {drem_ff, dq_ff[DVW-1]};
      m_trial = {mrem_ff, mq_ff[DVW-1]};
      dq_next = {dq_ff[DVW-2:0], d_trial >= {1'b0, prod_nn_ff}};

      // Digit-by-digit square root, two radicand bits per cycle.
      r_shift   = {rrem_ff[RRW-3:0], rad_ff[ROOT_IN_W-1 -: 2]};
      r_trial   = {root_ff, 2'b01};
      root_next = {root_ff[ROOT_W-2:0], r_shift >= r_trial};

      mean_q   = mq_ff[MEAN_W-1:0];
      mean_abs = mean_q + MEAN_W'(mrem_ff != '0);
      mean_val = sum_neg_ff ? -mean_abs : mean_q;

      unique case (state_ff)
         ST_IDLE: begin
            if (snap_valid) begin
               count_in    = snap_count;
               sum_neg_in  = snap_sum[SW-1];
               abs_sum_in  = abs_snap;
               min_in      = snap_min;
               max_in      = snap_max;
               ovf_in      = snap_ovf;
               mplier_n_in = snap_count;
               mcand_sq_in = PW'(snap_sumsq);
               mcand_n_in  = NW'(snap_count);
               mplier_s_in = abs_snap;
               mcand_s_in  = PW'(abs_snap);
               prod_nq_in  = '0;
               prod_nn_in  = '0;
               prod_ss_in  = '0;
               step_in     = '0;
               state_in    = ST_MUL;
            end
         end
         ST_MUL: begin
            if (mplier_n_ff[0]) begin
               prod_nq_in = prod_nq_ff + mcand_sq_ff;
               prod_nn_in = prod_nn_ff + mcand_n_ff;
            end
            if (mplier_s_ff[0]) begin
               prod_ss_in = prod_ss_ff + mcand_s_ff;
            end
            mplier_n_in = mplier_n_ff >> 1;
            mplier_s_in = mplier_s_ff >> 1;
            mcand_sq_in = mcand_sq_ff << 1;
            mcand_n_in  = mcand_n_ff << 1;
            mcand_s_in  = mcand_s_ff << 1;
            step_in     = step_ff + 1'b1;
            if (step_ff == STEP_W'(AW - 1)) begin
               state_in = ST_DIFF;
            end
         end
         ST_DIFF: begin
            dq_in    = {diff, {VAR_FRAC{1'b0}}};
            drem_in  = '0;
            mq_in    = DVW'({abs_sum_ff, {MEAN_FRAC{1'b0}}});
            mrem_in  = '0;
            step_in  = '0;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            dq_in   = dq_next;
            drem_in = dq_next[0] ? NW'(d_trial - {1'b0, prod_nn_ff}) : d_trial[NW-1:0];
            if (m_trial >= {1'b0, count_ff}) begin
               mrem_in = CW'(m_trial - {1'b0, count_ff});
               mq_in   = {mq_ff[DVW-2:0], 1'b1};
            end else begin
               mrem_in = m_trial[CW-1:0];
               mq_in   = {mq_ff[DVW-2:0], 1'b0};
            end
            step_in = step_ff + 1'b1;
            if (step_ff == STEP_W'(DVW - 1)) begin
               rad_in   = dq_next[ROOT_IN_W-1:0];
               rrem_in  = '0;
               root_in  = '0;
               step_in  = '0;
               state_in = ST_ROOT;
            end
         end
         ST_ROOT: begin
            rad_in  = rad_ff << 2;
            root_in = root_next;
            rrem_in = root_next[0] ? r_shift - r_trial : r_shift;
            step_in = step_ff + 1'b1;
            if (step_ff == STEP_W'(ROOT_W - 1)) begin
               rsp_valid_in             = 1'b1;
               rsp_data_in.max_value    = max_ff;
               rsp_data_in.min_value    = min_ff;
               rsp_data_in.mean_q8      = (count_ff == '0) ? '0 : mean_val;
               rsp_data_in.std_dev_q8   = (count_ff == '0) ? '0 : DEV_W'(root_next);
               rsp_data_in.sample_count = COUNT_OUT_W'(count_ff);
               rsp_data_in.overflowed   = ovf_ff;
               state_in                 = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      count_ff    <= count_in;
      sum_neg_ff  <= sum_neg_in;
      abs_sum_ff  <= abs_sum_in;
      min_ff      <= min_in;
      max_ff      <= max_in;
      ovf_ff      <= ovf_in;
      mplier_n_ff <= mplier_n_in;
      mcand_sq_ff <= mcand_sq_in;
      mcand_n_ff  <= mcand_n_in;
      prod_nq_ff  <= prod_nq_in;
      prod_nn_ff  <= prod_nn_in;
      mplier_s_ff <= mplier_s_in;
      mcand_s_ff  <= mcand_s_in;
      prod_ss_ff  <= prod_ss_in;
      dq_ff       <= dq_in;
      drem_ff     <= drem_in;
      mq_ff       <= mq_in;
      mrem_ff     <= mrem_in;
      rad_ff      <= rad_in;
      rrem_ff     <= rrem_in;
      root_ff     <= root_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

// ===== src/sample_set_statistics.sv =====
// Running statistics over sets of signed 16-bit samples.
// Input: a sample with its last_sample mark is accepted at a rising edge where
// start is high and busy is low. One sample can be accepted every cycle while busy is low.
// Output: after each marked sample, one transaction appears on rsp_data for a
// single cycle with rsp_valid high: max, min, mean (Q.8), population standard
// deviation (Q.8), sample count and an overflow flag. The receiver cannot
// stall; every result must be taken in the cycle it is shown.
// The front end accumulates count, sum, sum of squares, min and max, one
// sample per cycle while busy is low, and hands each finished set to a
// two-entry queue. The back end works one set at a time: shift-add products,
// two restoring dividers side by side and a square root, and it takes no
// new set from the queue until the last one is through. busy rises only
// when both queue slots are claimed, by two finished sets already waiting
// or by one and a last sample in the capture stage, so a stream of short
// sets can see it.
// Reset clears the running set, the queue and any result in progress.
module sample_set_statistics import sss_pkg::*; #(
   parameter int MAX_SAMPLES = DEFAULT_MAX_SAMPLES
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_valid,
   output rsp_type rsp_data
);

   localparam int CW     = $clog2(MAX_SAMPLES + 1);
   localparam int SW     = SAMPLE_W + CW;
   localparam int QW     = 2 * SAMPLE_W - 2 + CW;
   localparam int QCW    = $clog2(QUEUE_DEPTH + 1);
   localparam int SNAP_W = CW + SW + QW + 2 * SAMPLE_W + 1;

   logic                       snap_push;
   logic [CW-1:0]              f_count;
   logic signed [SW-1:0]       f_sum;
   logic [QW-1:0]              f_sumsq;
   logic signed [SAMPLE_W-1:0] f_min;
   logic signed [SAMPLE_W-1:0] f_max;
   logic                       f_ovf;

   logic [SNAP_W-1:0] push_data;
   logic [SNAP_W-1:0] queue_data;
   logic              queue_valid;
   logic              queue_pop;
   logic [QCW-1:0]    queue_level;

   logic [CW-1:0]              b_count;
   logic signed [SW-1:0]       b_sum;
   logic [QW-1:0]              b_sumsq;
   logic signed [SAMPLE_W-1:0] b_min;
   logic signed [SAMPLE_W-1:0] b_max;
   logic                       b_ovf;

   assign push_data = {f_count, f_sum, f_sumsq, f_min, f_max, f_ovf};
   assign {b_count, b_sum, b_sumsq, b_min, b_max, b_ovf} = queue_data;

   sss_front #(
      .MAX_SAMPLES (MAX_SAMPLES),
      .DEPTH       (QUEUE_DEPTH)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .req_data    (req_data),
      .busy        (busy),
      .queue_level (queue_level),
      .snap_push   (snap_push),
      .snap_count  (f_count),
      .snap_sum    (f_sum),
      .snap_sumsq  (f_sumsq),
      .snap_min    (f_min),
      .snap_max    (f_max),
      .snap_ovf    (f_ovf)
   );

   sss_queue #(
      .WIDTH (SNAP_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (snap_push),
      .push_data (push_data),
      .pop       (queue_pop),
      .out_valid (queue_valid),
      .out_data  (queue_data),
      .level     (queue_level)
   );

   sss_back #(
      .MAX_SAMPLES (MAX_SAMPLES)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .snap_valid (queue_valid),
      .snap_count (b_count),
      .snap_sum   (b_sum),
      .snap_sumsq (b_sumsq),
      .snap_min   (b_min),
      .snap_max   (b_max),
      .snap_ovf   (b_ovf),
      .snap_pop   (queue_pop),
      .rsp_valid  (rsp_valid),
      .rsp_data   (rsp_data)
   );

endmodule

// ===== sim/sample_set_statistics_checker.sv =====
`timescale 1ns / 100ps

module sample_set_statistics_checker import sss_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   input  logic    busy,
   input  req_type req_data,
   input  logic    rsp_valid,
   input  rsp_type rsp_data,
   output int      error_count,
   output int      results_waiting
);

   localparam int CAPACITY = DEFAULT_MAX_SAMPLES;

   rsp_type expected_summaries[$];

   // Running state of the set that is being collected.
   int unsigned                set_size;
   logic signed [26:0]         set_total;
   logic [40:0]                set_total_sq;
   logic signed [SAMPLE_W-1:0] set_low;
   logic signed [SAMPLE_W-1:0] set_high;
   logic                       set_dropped;
   int                         errors;

   initial begin
      error_count = 0;
      results_waiting = 0;
      errors = 0;
   end

   always @(posedge clock) begin : watch
      rsp_type            want;
      rsp_type            summary;
      longint             value;
      longint             numer;
      longint             mean;
      longint unsigned    n;
      longint unsigned    magnitude;
      longint unsigned    spread;
      longint unsigned    n_sq;
      longint unsigned    radicand;
      longint unsigned    root;
      longint unsigned    probe;
      logic               bad;

      if (reset) begin
         expected_summaries.delete();
         set_size = 0;
         set_total = '0;
         set_total_sq = '0;
         set_low = '0;
         set_high = '0;
         set_dropped = 1'b0;
      end else begin
         // Results are checked before the new sample is folded in, since a
         // result can never come out in the cycle of its own last sample.
         if (rsp_valid) begin
            if (expected_summaries.size() == 0) begin
               if (errors < 10)
                  $display("%0t: unexpected result: max %0d min %0d mean %0d dev %0d n %0d ovf %0b",
                           $realtime, rsp_data.max_value, rsp_data.min_value,
                           rsp_data.mean_q8, rsp_data.std_dev_q8,
                           rsp_data.sample_count, rsp_data.overflowed);
               errors++;
            end else begin
               want = expected_summaries.pop_front();
               bad = (rsp_data.max_value != want.max_value) ||
                     (rsp_data.min_value != want.min_value) ||
                     (rsp_data.mean_q8 != want.mean_q8) ||
                     (rsp_data.std_dev_q8 != want.std_dev_q8) ||
                     (rsp_data.sample_count != want.sample_count) ||
                     (rsp_data.overflowed != want.overflowed);
               if (bad) begin
                  if (errors < 10) begin
                     $display("%0t: result mismatch", $realtime);
                     $display("   expected: max %0d min %0d mean %0d dev %0d n %0d ovf %0b",
                              want.max_value, want.min_value, want.mean_q8,
                              want.std_dev_q8, want.sample_count, want.overflowed);
                     $display("   actual:   max %0d min %0d mean %0d dev %0d n %0d ovf %0b",
                              rsp_data.max_value, rsp_data.min_value,
                              rsp_data.mean_q8, rsp_data.std_dev_q8,
                              rsp_data.sample_count, rsp_data.overflowed);
                  end
                  errors++;
               end
            end
         end

         if (start && !busy) begin
            value = req_data.sample;
            if (set_size < CAPACITY) begin
               if (set_size == 0) begin
                  set_low = req_data.sample;
                  set_high = req_data.sample;
               end else begin
                  if (req_data.sample < set_low)
                     set_low = req_data.sample;
                  if (req_data.sample > set_high)
                     set_high = req_data.sample;
               end
               set_total = set_total + 27'(value);
               set_total_sq = set_total_sq + 41'(value * value);
               set_size++;
            end else begin
               set_dropped = 1'b1;
            end

            if (req_data.last_sample) begin
               mean = 0;
               root = 0;
               if (set_size != 0) begin
                  n = set_size;
                  value = set_total;
                  numer = value * 256;
                  mean = numer / longint'(n);
                  // Division truncates toward zero; the mean is floored.
                  if ((numer % longint'(n)) != 0 && numer < 0)
                     mean = mean - 1;

                  magnitude = (value < 0) ? longint'(-value) : longint'(value);
                  spread = n * longint'(set_total_sq);
                  if (spread >= magnitude * magnitude)
                     spread = spread - magnitude * magnitude;
                  else
                     spread = 0;
                  n_sq = n * n;
                  radicand = (spread / n_sq) * 65536 + ((spread % n_sq) * 65536) / n_sq;

                  // Digit-by-digit integer square root, floored.
                  probe = 64'd1 << 62;
                  while (probe > radicand)
                     probe = probe >> 2;
                  while (probe != 0) begin
                     if (radicand >= root + probe) begin
                        radicand = radicand - (root + probe);
                        root = (root >> 1) + probe;
                     end else begin
                        root = root >> 1;
                     end
                     probe = probe >> 2;
                  end
               end
               summary.max_value = set_high;
               summary.min_value = set_low;
               summary.mean_q8 = mean[MEAN_W-1:0];
               summary.std_dev_q8 = root[DEV_W-1:0];
               summary.sample_count = set_size[COUNT_OUT_W-1:0];
               summary.overflowed = set_dropped;
               expected_summaries.push_back(summary);

               set_size = 0;
               set_total = '0;
               set_total_sq = '0;
               set_low = '0;
               set_high = '0;
               set_dropped = 1'b0;
            end
         end
      end
      error_count <= errors;
      results_waiting <= expected_summaries.size();
   end

endmodule

// ===== sim/sample_set_statistics_test.sv =====
`timescale 1ns / 100ps

module sample_set_statistics_test import sss_pkg::*;;

   localparam int WATCHDOG_LIMIT = 4000;
   localparam int RANDOM_ITEMS   = 550;

   // Sample value styles for random sets.
   localparam int VALUES_FULL    = 0;
   localparam int VALUES_EXTREME = 1;
   localparam int VALUES_NARROW  = 2;
   localparam int VALUES_EDGE    = 3;

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_data;
   logic    rsp_valid;
   rsp_type rsp_data;

   int error_count;
   int results_waiting;
   int idle_pct;
   int items_sent;
   int quiet_cycles;

   sample_set_statistics uut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   sample_set_statistics_checker checker_i (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_data        (req_data),
      .rsp_valid       (rsp_valid),
      .rsp_data        (rsp_data),
      .error_count     (error_count),
      .results_waiting (results_waiting)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Ends the run when no transaction has moved for too long.
   initial quiet_cycles = 0;
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("FAIL");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   function automatic logic signed [SAMPLE_W-1:0] pick_sample(input int style);
      logic signed [SAMPLE_W-1:0] value;
      case (style)
         VALUES_EXTREME: begin
            value = $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
         end
         VALUES_NARROW: begin
            value = SAMPLE_W'($signed($urandom_range(8)) - 4);
         end
         VALUES_EDGE: begin
            if ($urandom_range(1))
               value = 16'sh7FFF - SAMPLE_W'($urandom_range(3));
            else
               value = 16'sh8000 + SAMPLE_W'($urandom_range(3));
         end
         default: begin
            value = SAMPLE_W'($urandom);
         end
      endcase
      return value;
   endfunction

   task automatic send_sample(input logic signed [SAMPLE_W-1:0] value, input logic mark);
      if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < idle_pct);
      end
      start <= 1'b1;
      req_data <= '{sample: value, last_sample: mark};
      do @(posedge clock); while (busy);
      items_sent++;
   endtask

   task automatic send_set(input int length, input int style);
      for (int i = 1; i <= length; i++)
         send_sample(pick_sample(style), i == length);
   endtask

   initial begin : stimulus
      int length;
      int set_index;
      int phase_pct[3];

      phase_pct = '{0, 82, 11};
      idle_pct = 0;
      items_sent = 0;
      reset <= 1'b1;
      start <= 1'b0;
      req_data <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Single-sample sets at both extremes, then the widest possible spread.
      send_sample(16'sh7FFF, 1'b1);
      send_sample(16'sh8000, 1'b1);
      send_sample(16'sh8000, 1'b0);
      send_sample(16'sh7FFF, 1'b1);
      send_sample(16'sh0000, 1'b1);
      // A negative mean that is not whole must be floored.
      send_sample(-16'sd1, 1'b0);
      send_sample(16'sd0, 1'b0);
      send_sample(16'sd0, 1'b1);
      // Equal samples give no deviation.
      repeat (3) send_sample(16'sd5, 1'b0);
      send_sample(16'sd5, 1'b1);
      repeat (2) send_sample(16'sh7FFF, 1'b0);
      send_sample(16'sh7FFF, 1'b1);
      repeat (2) send_sample(16'sh8000, 1'b0);
      send_sample(16'sh8000, 1'b1);
      send_sample(-16'sd3, 1'b0);
      send_sample(16'sd7, 1'b0);
      send_sample(-16'sd2, 1'b0);
      send_sample(16'sd100, 1'b0);
      send_sample(16'sh8000, 1'b1);

      // Sets at and beyond capacity; the mark of the last two lands on a
      // dropped sample, so the result carries the overflow flag.
      idle_pct = 11;
      for (int i = 1; i <= DEFAULT_MAX_SAMPLES; i++)
         send_sample(16'sh8000, i == DEFAULT_MAX_SAMPLES);
      idle_pct = 0;
      for (int i = 1; i <= DEFAULT_MAX_SAMPLES + 2; i++)
         send_sample(16'sh7FFF, i == DEFAULT_MAX_SAMPLES + 2);
      for (int i = 1; i <= DEFAULT_MAX_SAMPLES + 6; i++)
         send_sample(pick_sample($urandom_range(VALUES_EDGE)), i == DEFAULT_MAX_SAMPLES + 6);

      items_sent = 0;
      set_index = 0;
      while (items_sent < RANDOM_ITEMS) begin
         idle_pct = phase_pct[(set_index / 12) % 3];
         case ($urandom_range(19))
            0:             length = $urandom_range(60, 21);
            1, 2, 3, 4, 5: length = $urandom_range(20, 5);
            default:       length = $urandom_range(4, 1);
         endcase
         send_set(length, $urandom_range(VALUES_EDGE));
         set_index++;
      end
      start <= 1'b0;

      while (results_waiting != 0)
         @(posedge clock);
      repeat (150) @(posedge clock);
      if (error_count == 0 && results_waiting == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
